FILE: rtl/core/nfca_pkg.sv
// Shared types, codes, constants and lookup functions of the ISO 14443A activation sequencer.
package nfca_pkg;

	localparam int UID_BYTES = 10;
	localparam int UID_AW    = 4;

	localparam logic [7:0] REQA_BYTE       = 8'h26;
	localparam logic [2:0] REQA_BITS       = 3'd7;
	localparam logic [7:0] ANTICOLL_NVB    = 8'h20;
	localparam logic [7:0] SELECT_NVB      = 8'h70;
	localparam logic [7:0] RATS_CMD        = 8'hE0;
	localparam logic [7:0] RATS_PARAM      = 8'h80;
	localparam logic [7:0] CASCADE_TAG     = 8'h88;
	localparam logic [7:0] SAK_CASCADE_BIT = 8'h04;
	localparam logic [7:0] SAK_ISO4_BIT    = 8'h20;
	localparam logic [7:0] FSCI_MASK       = 8'h0F;
	localparam logic [8:0] DEFAULT_FS      = 9'd32;
	localparam logic [3:0] UID_LIMIT_RST   = 4'd10;
	localparam logic [1:0] LAST_LEVEL      = 2'd2;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_FRAME = 2'd1,
		CMD_ERROR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_TX   = 2'd0,
		KIND_UID  = 2'd1,
		KIND_DONE = 2'd2,
		KIND_FAIL = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		FRM_REQA     = 3'd0,
		FRM_ANTICOLL = 3'd1,
		FRM_SELECT   = 3'd2,
		FRM_RATS     = 3'd3,
		FRM_UID      = 3'd4,
		FRM_DONE     = 3'd5,
		FRM_FAIL     = 3'd6
	} frm_t;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_ATQA = 5'b00010,
		PH_AC   = 5'b00100,
		PH_SAK  = 5'b01000,
		PH_ATS  = 5'b10000
	} phase_t;

	// one frame or report to stream out
	typedef struct packed {
		frm_t       frm;
		logic [3:0] len;
		logic       fail_code;
	} emit_job_t;

	// card state the emitter reads while streaming
	typedef struct packed {
		logic [1:0]      level;
		logic [7:0]      final_sak;
		logic [8:0]      fs;
		logic            iso;
		logic [4:0][7:0] held;
	} emit_ctx_t;

	function automatic logic [7:0] sel_code(input logic [1:0] level);
		logic [7:0] code;
		unique case (level)
			2'd1:    code = 8'h95;
			2'd2:    code = 8'h97;
			default: code = 8'h93;
		endcase
		return code;
	endfunction

	function automatic logic [8:0] fsc_size(input logic [3:0] fsci);
		logic [8:0] size;
		unique case (fsci)
			4'd0:    size = 9'd16;
			4'd1:    size = 9'd24;
			4'd2:    size = 9'd32;
			4'd3:    size = 9'd40;
			4'd4:    size = 9'd48;
			4'd5:    size = 9'd64;
			4'd6:    size = 9'd96;
			4'd7:    size = 9'd128;
			default: size = 9'd256;
		endcase
		return size;
	endfunction

endpackage

FILE: rtl/core/nfca_seq.sv
// Activation sequencer: decodes each beat, runs the BCC and UID-append loops, schedules frames.
module nfca_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            in_cmd,
	input  logic [47:0]           in_data,
	input  logic [3:0]            uid_limit,
	output logic                  emit_start,
	output nfca_pkg::emit_job_t   job,
	output nfca_pkg::emit_ctx_t   ctx,
	input  logic                  emit_busy,
	input  logic [3:0]            uid_raddr,
	output logic [7:0]            uid_rdata
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECODE = 6'b000010,
		ST_BCC    = 6'b000100,
		ST_APPEND = 6'b001000,
		ST_DECIDE = 6'b010000,
		ST_EMIT   = 6'b100000
	} st_t;

	st_t                  st_q;
	nfca_pkg::phase_t     phase_q;
	nfca_pkg::cmd_t       cmd_q;
	logic [7:0]           len_q;
	logic [4:0][7:0]      rx_q;
	logic [4:0][7:0]      held_q;
	logic [7:0]           uid_store_q [nfca_pkg::UID_BYTES];
	logic [3:0]           uid_count_q;
	logic [1:0]           level_q;
	logic [7:0]           final_sak_q;
	logic [8:0]           card_fs_q;
	logic                 layer4_q;
	logic [2:0]           idx_q;
	logic [7:0]           bcc_q;
	logic                 start_q;
	nfca_pkg::emit_job_t  job_q;

	logic [7:0] bcc_next;
	logic [3:0] finish_n;
	logic [7:0] tl;

	assign in_ready   = (st_q == ST_IDLE);
	assign emit_start = start_q;
	assign job        = job_q;
	assign bcc_next   = bcc_q ^ rx_q[idx_q];
	assign finish_n   = (uid_count_q < uid_limit) ? uid_count_q : uid_limit;
	assign tl         = rx_q[0];

	assign uid_rdata = (uid_raddr < 4'(nfca_pkg::UID_BYTES)) ? uid_store_q[uid_raddr] : 8'h00;

	always_comb begin
		ctx.level     = level_q;
		ctx.final_sak = final_sak_q;
		ctx.fs        = layer4_q ? card_fs_q : nfca_pkg::DEFAULT_FS;
		ctx.iso       = layer4_q;
		ctx.held      = held_q;
	end

	// payload: captured beat, held response, UID store
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			len_q <= in_data[7:0];
			rx_q  <= in_data[47:8];
		end
		if (st_q == ST_BCC && idx_q == 3'd3 && bcc_next == rx_q[4])
			held_q <= rx_q;
		if (st_q == ST_APPEND && uid_count_q < 4'(nfca_pkg::UID_BYTES))
			uid_store_q[uid_count_q] <= held_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			phase_q     <= nfca_pkg::PH_IDLE;
			cmd_q       <= nfca_pkg::CMD_NONE;
			uid_count_q <= '0;
			level_q     <= '0;
			final_sak_q <= '0;
			card_fs_q   <= '0;
			layer4_q    <= 1'b0;
			idx_q       <= '0;
			bcc_q       <= '0;
			start_q     <= 1'b0;
			job_q       <= '{frm: nfca_pkg::FRM_FAIL, len: 4'd1, fail_code: 1'b0};
		end else begin
			start_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q <= nfca_pkg::cmd_t'(in_cmd);
						st_q  <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					st_q <= ST_IDLE;
					unique case (cmd_q)
						nfca_pkg::CMD_START: begin
							level_q     <= '0;
							uid_count_q <= '0;
							final_sak_q <= '0;
							card_fs_q   <= '0;
							layer4_q    <= 1'b0;
							phase_q     <= nfca_pkg::PH_ATQA;
							job_q       <= '{frm: nfca_pkg::FRM_REQA, len: 4'd1, fail_code: 1'b0};
							start_q     <= 1'b1;
							st_q        <= ST_EMIT;
						end
						nfca_pkg::CMD_ERROR: begin
							if (phase_q != nfca_pkg::PH_IDLE) begin
								job_q <= '{frm: nfca_pkg::FRM_FAIL, len: 4'd1,
									fail_code: (phase_q != nfca_pkg::PH_ATQA)};
								phase_q <= nfca_pkg::PH_IDLE;
								start_q <= 1'b1;
								st_q    <= ST_EMIT;
							end
						end
						nfca_pkg::CMD_FRAME: begin
							unique case (phase_q)
								nfca_pkg::PH_ATQA: begin
									start_q <= 1'b1;
									st_q    <= ST_EMIT;
									if (len_q != 8'd2) begin
										job_q   <= '{frm: nfca_pkg::FRM_FAIL, len: 4'd1, fail_code: 1'b0};
										phase_q <= nfca_pkg::PH_IDLE;
									end else begin
										job_q   <= '{frm: nfca_pkg::FRM_ANTICOLL, len: 4'd2, fail_code: 1'b0};
										phase_q <= nfca_pkg::PH_AC;
									end
								end
								nfca_pkg::PH_AC: begin
									if (len_q != 8'd5) begin
										job_q   <= '{frm: nfca_pkg::FRM_FAIL, len: 4'd1, fail_code: 1'b1};
										phase_q <= nfca_pkg::PH_IDLE;
										start_q <= 1'b1;
										st_q    <= ST_EMIT;
									end else begin
										bcc_q <= '0;
										idx_q <= '0;
										st_q  <= ST_BCC;
									end
								end
								nfca_pkg::PH_SAK: begin
									if (len_q != 8'd1) begin
										job_q   <= '{frm: nfca_pkg::FRM_FAIL, len: 4'd1, fail_code: 1'b1};
										phase_q <= nfca_pkg::PH_IDLE;
										start_q <= 1'b1;
										st_q    <= ST_EMIT;
									end else begin
										// drop the cascade tag from the UID
										idx_q <= (held_q[0] == nfca_pkg::CASCADE_TAG) ? 3'd1 : 3'd0;
										st_q  <= ST_APPEND;
									end
								end
								nfca_pkg::PH_ATS: begin
									start_q <= 1'b1;
									st_q    <= ST_EMIT;
									phase_q <= nfca_pkg::PH_IDLE;
									if (len_q == 8'd0) begin
										job_q <= '{frm: nfca_pkg::FRM_FAIL, len: 4'd1, fail_code: 1'b1};
									end else begin
										if (len_q >= tl && tl > 8'd1)
											card_fs_q <= nfca_pkg::fsc_size(
												4'(rx_q[1] & nfca_pkg::FSCI_MASK));
										else
											card_fs_q <= nfca_pkg::DEFAULT_FS;
										layer4_q <= 1'b1;
										if (finish_n == 4'd0)
											job_q <= '{frm: nfca_pkg::FRM_DONE, len: 4'd1,
												fail_code: 1'b0};
										else
											job_q <= '{frm: nfca_pkg::FRM_UID, len: finish_n,
												fail_code: 1'b0};
									end
								end
								default: begin
									st_q <= ST_IDLE;
								end
							endcase
						end
						default: begin
							st_q <= ST_IDLE;
						end
					endcase
				end
				ST_BCC: begin
					// one byte of the XOR check per cycle
					if (idx_q == 3'd3) begin
						start_q <= 1'b1;
						st_q    <= ST_EMIT;
						if (bcc_next != rx_q[4]) begin
							job_q   <= '{frm: nfca_pkg::FRM_FAIL, len: 4'd1, fail_code: 1'b1};
							phase_q <= nfca_pkg::PH_IDLE;
						end else begin
							job_q   <= '{frm: nfca_pkg::FRM_SELECT, len: 4'd7, fail_code: 1'b0};
							phase_q <= nfca_pkg::PH_SAK;
						end
					end else begin
						bcc_q <= bcc_next;
						idx_q <= idx_q + 3'd1;
					end
				end
				ST_APPEND: begin
					if (uid_count_q < 4'(nfca_pkg::UID_BYTES))
						uid_count_q <= uid_count_q + 4'd1;
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd3)
						st_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					start_q <= 1'b1;
					st_q    <= ST_EMIT;
					if ((rx_q[0] & nfca_pkg::SAK_CASCADE_BIT) != 8'h00) begin
						if (level_q >= nfca_pkg::LAST_LEVEL) begin
							job_q   <= '{frm: nfca_pkg::FRM_FAIL, len: 4'd1, fail_code: 1'b1};
							phase_q <= nfca_pkg::PH_IDLE;
						end else begin
							level_q <= level_q + 2'd1;
							job_q   <= '{frm: nfca_pkg::FRM_ANTICOLL, len: 4'd2, fail_code: 1'b0};
							phase_q <= nfca_pkg::PH_AC;
						end
					end else begin
						final_sak_q <= rx_q[0];
						if ((rx_q[0] & nfca_pkg::SAK_ISO4_BIT) != 8'h00) begin
							job_q   <= '{frm: nfca_pkg::FRM_RATS, len: 4'd2, fail_code: 1'b0};
							phase_q <= nfca_pkg::PH_ATS;
						end else begin
							phase_q <= nfca_pkg::PH_IDLE;
							if (finish_n == 4'd0)
								job_q <= '{frm: nfca_pkg::FRM_DONE, len: 4'd1, fail_code: 1'b0};
							else
								job_q <= '{frm: nfca_pkg::FRM_UID, len: finish_n, fail_code: 1'b0};
						end
					end
				end
				ST_EMIT: begin
					// hold until the emitter has loaded the final beat
					if (!start_q && !emit_busy)
						st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/nfca_emit.sv
// Result emitter: formats job beats one per cycle unless stalled, into a registered output.
module nfca_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  nfca_pkg::emit_job_t  job,
	input  nfca_pkg::emit_ctx_t  ctx,
	output logic                 busy,
	output logic [3:0]           uid_raddr,
	input  logic [7:0]           uid_rdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [39:0]          m_axis_tdata,
	output logic [1:0]           m_axis_tuser,
	output logic                 m_axis_tlast
);

	logic                 busy_q;
	nfca_pkg::emit_job_t  job_q;
	logic [3:0]           bi_q;
	logic                 out_valid_q;
	logic [39:0]          out_data_q;
	logic [1:0]           out_kind_q;
	logic                 out_last_q;

	logic                 load;
	logic                 is_last;
	logic [3:0]           bi_m2;
	nfca_pkg::kind_t      kind;
	logic [7:0]           data_byte;
	logic [2:0]           tx_bits;
	logic                 crc_on;
	logic [3:0]           uid_length;
	logic [7:0]           sak_value;
	logic [8:0]           frame_size;
	logic                 iso4_active;
	logic                 fail_code;

	assign busy          = busy_q;
	assign uid_raddr     = bi_q;
	assign load          = busy_q && (!out_valid_q || m_axis_tready);
	assign is_last       = (bi_q == job_q.len - 4'd1);
	assign bi_m2         = bi_q - 4'd2;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	always_comb begin
		kind        = nfca_pkg::KIND_TX;
		data_byte   = 8'h00;
		tx_bits     = 3'd0;
		crc_on      = 1'b0;
		uid_length  = 4'd0;
		sak_value   = 8'h00;
		frame_size  = 9'd0;
		iso4_active = 1'b0;
		fail_code   = 1'b0;
		unique case (job_q.frm)
			nfca_pkg::FRM_REQA: begin
				data_byte = nfca_pkg::REQA_BYTE;
				tx_bits   = nfca_pkg::REQA_BITS;
			end
			nfca_pkg::FRM_ANTICOLL: begin
				data_byte = (bi_q == 4'd0) ? nfca_pkg::sel_code(ctx.level) : nfca_pkg::ANTICOLL_NVB;
			end
			nfca_pkg::FRM_SELECT: begin
				crc_on = 1'b1;
				unique case (bi_q)
					4'd0:    data_byte = nfca_pkg::sel_code(ctx.level);
					4'd1:    data_byte = nfca_pkg::SELECT_NVB;
					default: data_byte = ctx.held[bi_m2[2:0]];
				endcase
			end
			nfca_pkg::FRM_RATS: begin
				crc_on    = 1'b1;
				data_byte = (bi_q == 4'd0) ? nfca_pkg::RATS_CMD : nfca_pkg::RATS_PARAM;
			end
			nfca_pkg::FRM_UID: begin
				kind        = nfca_pkg::KIND_UID;
				data_byte   = uid_rdata;
				uid_length  = job_q.len;
				sak_value   = ctx.final_sak;
				frame_size  = ctx.fs;
				iso4_active = ctx.iso;
			end
			nfca_pkg::FRM_DONE: begin
				kind        = nfca_pkg::KIND_DONE;
				sak_value   = ctx.final_sak;
				frame_size  = ctx.fs;
				iso4_active = ctx.iso;
			end
			default: begin
				kind      = nfca_pkg::KIND_FAIL;
				fail_code = job_q.fail_code;
			end
		endcase
	end

	// payload of the output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= {5'd0, fail_code, iso4_active, frame_size, sak_value, uid_length,
				crc_on, tx_bits, data_byte};
			out_kind_q <= kind;
			out_last_q <= is_last;
		end
		if (start)
			job_q <= job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			bi_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				bi_q   <= '0;
			end else if (load) begin
				bi_q <= bi_q + 4'd1;
				if (is_last)
					busy_q <= 1'b0;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/core/nfc_type_a_activation.sv
// Reader-side ISO 14443A activation: UID limit register, sequencer and result emitter.
// Path: an input beat is captured and decoded; an anticollision reply then runs the BCC loop,
// a SAK reply the UID append and decision states, before the emitter loads the output register.
// Throughput: one result beat per cycle while the output is not stalled; an item holds the input
// until the last of its result beats (at most 10) is loaded; an ignored beat holds it through decode.
// Reset (arst_n low, asynchronous): sequencer idle, card state cleared, UID limit 10.
module nfc_type_a_activation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,      // uid_out_limit
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // rx_len, rx_byte0, rx_byte1, rx_byte2, rx_byte3, rx_byte4
	input  logic [1:0]  s_axis_tuser,   // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // data_byte, tx_bits, crc_on, uid_length, sak_value,
	                                    // frame_size, iso4_active, fail_code, zero pad
	output logic [1:0]  m_axis_tuser,   // kind
	output logic        m_axis_tlast
);

	logic                 uid_limit_q;
	logic [3:0]           limit_q;
	logic                 emit_start;
	logic                 emit_busy;
	nfca_pkg::emit_job_t  job;
	nfca_pkg::emit_ctx_t  ctx;
	logic [3:0]           uid_raddr;
	logic [7:0]           uid_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= nfca_pkg::UID_LIMIT_RST;
			uid_limit_q <= 1'b0;
		end else begin
			uid_limit_q <= cfg_we;
			if (cfg_we)
				limit_q <= cfg_wdata;
		end
	end

	nfca_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_cmd     (s_axis_tuser),
		.in_data    (s_axis_tdata),
		.uid_limit  (limit_q),
		.emit_start (emit_start),
		.job        (job),
		.ctx        (ctx),
		.emit_busy  (emit_busy || uid_limit_q),
		.uid_raddr  (uid_raddr),
		.uid_rdata  (uid_rdata)
	);

	nfca_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (emit_start),
		.job           (job),
		.ctx           (ctx),
		.busy          (emit_busy),
		.uid_raddr     (uid_raddr),
		.uid_rdata     (uid_rdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

FILE: tb/sv/testbench.sv
// Self-checking bench for the ISO 14443A activation sequencer: directed table, then random card runs.
module testbench;
	import nfca_pkg::*;

	localparam int RUN_LIMIT     = 400000;
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 24;
	localparam int RUN_ITEMS     = 26;
	localparam int PLAN_STEPS    = 5;
	// frame sizes by FSCI, index 0 in the lowest bits
	localparam logic [8:0][8:0] FS_BY_FSCI = {9'd256, 9'd128, 9'd96, 9'd64, 9'd48,
		9'd40, 9'd32, 9'd24, 9'd16};

	typedef enum logic [2:0] {
		ROW_MODEL,
		ROW_QUIET,
		ROW_REQA,
		ROW_FAIL0,
		ROW_FAIL1
	} row_mode_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
		logic [2:0] txb;
		logic       crc;
		logic [3:0] ulen;
		logic [7:0] sak;
		logic [8:0] fs;
		logic       iso;
		logic       fc;
	} result_beat_t;

	typedef struct {
		row_mode_t  mode;
		cmd_t       cmd;
		logic [7:0] len;
		logic [39:0] rx;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [3:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// own copy of the card and sequencer state
	phase_t      seq_phase;
	logic [1:0]  seq_level;
	logic [7:0]  uid_mem [UID_BYTES];
	int          uid_cnt;
	logic [7:0]  held [5];
	logic [7:0]  card_sak;
	logic [8:0]  card_fs;
	logic        layer4;
	logic [3:0]  uid_limit;

	result_beat_t step_results[$];
	result_beat_t pending_results[$];
	result_beat_t want_beat;
	stim_row_t    stim_rows[$];

	int mismatches = 0;
	int live_items;
	int rx_hold = 0;
	bit tx_idle_on;
	bit rx_idle_on;

	nfc_type_a_activation dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void push_beat(input kind_t k, input logic [7:0] d, input logic [2:0] txb,
			input logic crc, input logic [3:0] ul, input logic [7:0] sk, input logic [8:0] fs,
			input logic iso, input logic fc);
		result_beat_t r;
		r.kind = k;
		r.data = d;
		r.last = 1'b0;
		r.txb  = txb;
		r.crc  = crc;
		r.ulen = ul;
		r.sak  = sk;
		r.fs   = fs;
		r.iso  = iso;
		r.fc   = fc;
		step_results.push_back(r);
	endfunction

	function automatic void fail_run(input logic fc);
		seq_phase = PH_IDLE;
		push_beat(KIND_FAIL, 8'h00, 3'd0, 1'b0, 4'd0, 8'h00, 9'd0, 1'b0, fc);
	endfunction

	function automatic logic [7:0] sel_byte();
		return 8'h93 + {5'd0, seq_level, 1'b0};
	endfunction

	function automatic void ask_anticoll();
		seq_phase = PH_AC;
		push_beat(KIND_TX, sel_byte(), 3'd0, 1'b0, 4'd0, 8'h00, 9'd0, 1'b0, 1'b0);
		push_beat(KIND_TX, ANTICOLL_NVB, 3'd0, 1'b0, 4'd0, 8'h00, 9'd0, 1'b0, 1'b0);
	endfunction

	function automatic void append_uid(input logic [7:0] b);
		if (uid_cnt < UID_BYTES) begin
			uid_mem[uid_cnt] = b;
			uid_cnt++;
		end
	endfunction

	function automatic void report_uid();
		int n;
		int i;
		logic [8:0] fs;
		n = (uid_cnt < uid_limit) ? uid_cnt : uid_limit;
		if (n > UID_BYTES)
			n = UID_BYTES;
		fs = layer4 ? card_fs : DEFAULT_FS;
		seq_phase = PH_IDLE;
		if (n == 0)
			push_beat(KIND_DONE, 8'h00, 3'd0, 1'b0, 4'd0, card_sak, fs, layer4, 1'b0);
		else
			for (i = 0; i < n; i++)
				push_beat(KIND_UID, uid_mem[i], 3'd0, 1'b0, 4'(n), card_sak, fs, layer4, 1'b0);
	endfunction

	// work out every result beat one accepted input beat causes
	function automatic void predict_activation(input cmd_t cmd, input logic [7:0] len,
			input logic [39:0] rx);
		logic [7:0] b [5];
		logic [7:0] sak;
		logic [3:0] fsci;
		result_beat_t r;
		int i;
		for (i = 0; i < 5; i++)
			b[i] = rx[8*i +: 8];
		sak = b[0];
		step_results.delete();
		case (cmd)
			CMD_START: begin
				seq_level = 2'd0;
				uid_cnt   = 0;
				card_sak  = 8'h00;
				card_fs   = 9'd0;
				layer4    = 1'b0;
				seq_phase = PH_ATQA;
				push_beat(KIND_TX, REQA_BYTE, REQA_BITS, 1'b0, 4'd0, 8'h00, 9'd0, 1'b0, 1'b0);
			end
			CMD_ERROR: begin
				if (seq_phase != PH_IDLE)
					fail_run(seq_phase != PH_ATQA);
			end
			CMD_FRAME: begin
				case (seq_phase)
					PH_ATQA: begin
						if (len != 8'd2)
							fail_run(1'b0);
						else
							ask_anticoll();
					end
					PH_AC: begin
						if (len != 8'd5 || (b[0] ^ b[1] ^ b[2] ^ b[3]) != b[4]) begin
							fail_run(1'b1);
						end else begin
							for (i = 0; i < 5; i++)
								held[i] = b[i];
							push_beat(KIND_TX, sel_byte(), 3'd0, 1'b1, 4'd0, 8'h00, 9'd0,
								1'b0, 1'b0);
							push_beat(KIND_TX, SELECT_NVB, 3'd0, 1'b1, 4'd0, 8'h00, 9'd0,
								1'b0, 1'b0);
							for (i = 0; i < 5; i++)
								push_beat(KIND_TX, held[i], 3'd0, 1'b1, 4'd0, 8'h00, 9'd0,
									1'b0, 1'b0);
							seq_phase = PH_SAK;
						end
					end
					PH_SAK: begin
						if (len != 8'd1) begin
							fail_run(1'b1);
						end else begin
							// drop the cascade tag, keep the rest of the UID part
							for (i = (held[0] == CASCADE_TAG) ? 1 : 0; i < 4; i++)
								append_uid(held[i]);
							if ((sak & SAK_CASCADE_BIT) != 8'h00) begin
								if (seq_level >= LAST_LEVEL) begin
									fail_run(1'b1);
								end else begin
									seq_level++;
									ask_anticoll();
								end
							end else begin
								card_sak = sak;
								if ((sak & SAK_ISO4_BIT) != 8'h00) begin
									seq_phase = PH_ATS;
									push_beat(KIND_TX, RATS_CMD, 3'd0, 1'b1, 4'd0, 8'h00,
										9'd0, 1'b0, 1'b0);
									push_beat(KIND_TX, RATS_PARAM, 3'd0, 1'b1, 4'd0, 8'h00,
										9'd0, 1'b0, 1'b0);
								end else begin
									report_uid();
								end
							end
						end
					end
					PH_ATS: begin
						if (len == 8'd0) begin
							fail_run(1'b1);
						end else begin
							if (len >= b[0] && b[0] > 8'd1) begin
								fsci = b[1][3:0];
								card_fs = (fsci <= 4'd8) ? FS_BY_FSCI[fsci] : 9'd256;
							end else begin
								card_fs = DEFAULT_FS;
							end
							layer4 = 1'b1;
							report_uid();
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		if (step_results.size() > 0) begin
			r = step_results.pop_back();
			r.last = 1'b1;
			step_results.push_back(r);
		end
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic logic [39:0] rand_frame();
		return {8'($urandom), 32'($urandom)};
	endfunction

	task automatic add_row(input row_mode_t mode, input cmd_t cmd, input logic [7:0] len,
			input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
			input logic [7:0] b3, input logic [7:0] b4);
		stim_row_t row;
		row.mode = mode;
		row.cmd  = cmd;
		row.len  = len;
		row.rx   = {b4, b3, b2, b1, b0};
		stim_rows.push_back(row);
	endtask

	task automatic send_item(input row_mode_t mode, input cmd_t cmd, input logic [7:0] len,
			input logic [39:0] rx);
		int gap;
		result_beat_t typed;
		gap = tx_idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {rx, len};
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		predict_activation(cmd, len, rx);
		if (step_results.size() > 0)
			live_items++;
		typed = '0;
		typed.last = 1'b1;
		case (mode)
			ROW_MODEL: begin
				foreach (step_results[i])
					pending_results.push_back(step_results[i]);
			end
			ROW_REQA: begin
				typed.kind = KIND_TX;
				typed.data = REQA_BYTE;
				typed.txb  = REQA_BITS;
				pending_results.push_back(typed);
			end
			ROW_FAIL0, ROW_FAIL1: begin
				typed.kind = KIND_FAIL;
				typed.fc   = (mode == ROW_FAIL1);
				pending_results.push_back(typed);
			end
			default: ;
		endcase
	endtask

	// now and then break a beat: bad length, flipped bit, error, nothing, restart
	task automatic send_noisy(input cmd_t cmd, input logic [7:0] len, input logic [39:0] rx);
		cmd_t c;
		logic [7:0] l;
		logic [39:0] d;
		int k;
		c = cmd;
		l = len;
		d = rx;
		k = $urandom_range(0, 39);
		if ($urandom_range(0, 11) == 0) begin
			case ($urandom_range(0, 4))
				0: l = 8'($urandom);
				1: d[k] = ~d[k];
				2: c = CMD_ERROR;
				3: c = CMD_NONE;
				default: c = CMD_START;
			endcase
		end
		send_item(ROW_MODEL, c, l, d);
	endtask

	task automatic run_card();
		int levels;
		int lv;
		int ats_len;
		logic [7:0] sak;
		logic [39:0] rx;
		levels = $urandom_range(1, 3);
		sak = 8'h00;
		send_noisy(CMD_START, 8'($urandom), rand_frame());
		send_noisy(CMD_FRAME, 8'd2, rand_frame());
		for (lv = 0; lv < levels; lv++) begin
			rx = rand_frame();
			if (lv < levels - 1 && $urandom_range(0, 3) != 0)
				rx[7:0] = CASCADE_TAG;
			rx[39:32] = rx[7:0] ^ rx[15:8] ^ rx[23:16] ^ rx[31:24];
			send_noisy(CMD_FRAME, 8'd5, rx);
			rx = rand_frame();
			sak = rx[7:0];
			if (lv < levels - 1)
				sak |= SAK_CASCADE_BIT;
			else if (!(lv == 2 && $urandom_range(0, 5) == 0))
				sak &= ~SAK_CASCADE_BIT;
			rx[7:0] = sak;
			send_noisy(CMD_FRAME, 8'd1, rx);
		end
		if ((sak & SAK_ISO4_BIT) != 8'h00) begin
			ats_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6);
			rx = rand_frame();
			if ($urandom_range(0, 5) != 0)
				rx[7:0] = 8'($urandom_range(0, ats_len + 1));
			send_noisy(CMD_FRAME, 8'(ats_len), rx);
		end
		if ($urandom_range(0, 3) == 0)
			send_item(ROW_MODEL, cmd_t'($urandom_range(0, 3)), 8'($urandom), rand_frame());
	endtask

	task automatic set_uid_limit(input logic [3:0] value);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		uid_limit = value;
	endtask

	// take result beats and check them against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected: expected none, actual kind %0d data %02h",
					$time, m_axis_tuser, m_axis_tdata[7:0]);
				mismatches++;
			end else begin
				want_beat = pending_results.pop_front();
				check_field("kind", want_beat.kind, m_axis_tuser);
				check_field("data_byte", want_beat.data, m_axis_tdata[7:0]);
				check_field("last", want_beat.last, m_axis_tlast);
				check_field("tx_bits", want_beat.txb, m_axis_tdata[10:8]);
				check_field("crc_on", want_beat.crc, m_axis_tdata[11]);
				check_field("uid_length", want_beat.ulen, m_axis_tdata[15:12]);
				check_field("sak_value", want_beat.sak, m_axis_tdata[23:16]);
				check_field("frame_size", want_beat.fs, m_axis_tdata[32:24]);
				check_field("iso4_active", want_beat.iso, m_axis_tdata[33]);
				check_field("fail_code", want_beat.fc, m_axis_tdata[34]);
			end
			rx_hold = rx_idle_on ? $urandom_range(0, 3) : 0;
		end
	end

	// hold ready low for the drawn stall, sometimes before the first beat too
	always @(negedge clk) begin
		if (!m_axis_tvalid && rx_idle_on && rx_hold == 0 && $urandom_range(0, 7) == 0)
			rx_hold = $urandom_range(1, 3);
		if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("nfc_type_a_activation regression: fail");
		$finish;
	end

	initial begin
		logic [3:0] limit_plan [PLAN_STEPS];
		int step;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 4'd0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_NONE;
		m_axis_tready = 1'b0;
		seq_phase     = PH_IDLE;
		seq_level     = 2'd0;
		uid_cnt       = 0;
		card_sak      = 8'h00;
		card_fs       = 9'd0;
		layer4        = 1'b0;
		uid_limit     = UID_LIMIT_RST;
		tx_idle_on    = 1'b1;
		rx_idle_on    = 1'b1;
		live_items    = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// frames, errors and an empty command with no activation running
		add_row(ROW_QUIET, CMD_FRAME, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		add_row(ROW_QUIET, CMD_ERROR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(ROW_QUIET, CMD_NONE, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		// no card: bad ATQA length, then transceiver error
		add_row(ROW_REQA, CMD_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		add_row(ROW_FAIL0, CMD_FRAME, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(ROW_REQA, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(ROW_FAIL0, CMD_ERROR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		// restart mid-anticollision, then a BCC mismatch
		add_row(ROW_REQA, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(ROW_MODEL, CMD_FRAME, 8'h02, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(ROW_REQA, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(ROW_MODEL, CMD_FRAME, 8'h02, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(ROW_FAIL1, CMD_FRAME, 8'h05, 8'h11, 8'h22, 8'h33, 8'h44, 8'h00);
		// triple UID without cascade tags: overflow, RATS, FSCI above eight
		add_row(ROW_REQA, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(ROW_MODEL, CMD_FRAME, 8'h02, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(ROW_MODEL, CMD_FRAME, 8'h05, 8'h11, 8'h22, 8'h33, 8'h44, 8'h44);
		add_row(ROW_MODEL, CMD_FRAME, 8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(ROW_MODEL, CMD_FRAME, 8'h05, 8'h55, 8'h66, 8'h77, 8'h08, 8'h4C);
		add_row(ROW_MODEL, CMD_FRAME, 8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(ROW_MODEL, CMD_FRAME, 8'h05, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00);
		add_row(ROW_MODEL, CMD_FRAME, 8'h01, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(ROW_MODEL, CMD_FRAME, 8'h02, 8'h02, 8'h0F, 8'h00, 8'h00, 8'h00);
		// cascade bit on the third level asks for a fourth
		add_row(ROW_REQA, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(ROW_MODEL, CMD_FRAME, 8'h02, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(ROW_MODEL, CMD_FRAME, 8'h05, 8'h88, 8'h01, 8'h02, 8'h03, 8'h88);
		add_row(ROW_MODEL, CMD_FRAME, 8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(ROW_MODEL, CMD_FRAME, 8'h05, 8'h88, 8'hA5, 8'h5A, 8'h00, 8'h77);
		add_row(ROW_MODEL, CMD_FRAME, 8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(ROW_MODEL, CMD_FRAME, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(ROW_FAIL1, CMD_FRAME, 8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00);

		foreach (stim_rows[r])
			send_item(stim_rows[r].mode, stim_rows[r].cmd, stim_rows[r].len, stim_rows[r].rx);

		limit_plan[0] = 4'd0;
		limit_plan[1] = 4'd10;
		limit_plan[2] = 4'd1;
		limit_plan[3] = 4'($urandom_range(2, 9));
		limit_plan[4] = 4'd7;
		for (step = 0; step < PLAN_STEPS; step++) begin
			set_uid_limit(limit_plan[step]);
			// one stretch runs back to back on both sides
			tx_idle_on = (step != 2);
			rx_idle_on = (step != 2);
			live_items = 0;
			while (live_items < RUN_ITEMS)
				run_card();
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("nfc_type_a_activation regression: pass");
		else
			$display("nfc_type_a_activation regression: fail");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/nfca_pkg.sv
rtl/core/nfca_seq.sv
rtl/core/nfca_emit.sv
rtl/core/nfc_type_a_activation.sv
tb/sv/testbench.sv
